### sv/torus_vertex_generator_core_macros.svh
// Assertion macros shared by the torus vertex generator RTL.
`ifndef TORUS_VERTEX_GENERATOR_CORE_MACROS_SVH
`define TORUS_VERTEX_GENERATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TVG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("torus vertex generator check failed");

// The consequent must hold in the cycle after the antecedent.
`define TVG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("torus vertex generator check failed");

`endif

### sv/tvg_pkg.sv
// Shared constants, register codes and table functions of the torus vertex generator.
package tvg_pkg;

    // Largest step count honoured around either circle.
    localparam int MAX_STEPS = 256;

    // Divisor width: twice a clamped nine bit count.
    localparam int DIV_W = 10;

    // Configuration register codes.
    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t REG_MAJOR_COUNT  = 2'd0;
    localparam cfg_idx_t REG_MINOR_COUNT  = 2'd1;
    localparam cfg_idx_t REG_MAJOR_RADIUS = 2'd2;
    localparam cfg_idx_t REG_MINOR_RADIUS = 2'd3;

    // Q30 Taylor coefficients of sin(pi/2 * t).
    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint K_C1    = 64'sd1686629713;
    localparam longint K_C3    = -64'sd693598668;
    localparam longint K_C5    = 64'sd85569306;
    localparam longint K_C7    = -64'sd5026996;
    localparam longint K_C9    = 64'sd172272;
    localparam longint K_C11   = -64'sd3864;

    // Q30 product, truncated toward zero.
    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b) / Q30_ONE;
    endfunction

    // Quarter-wave sine entry k of a table whose depth is 2**log_depth, in Q1.14.
    function automatic logic [14:0] quarter_entry(input int unsigned k,
                                                  input int unsigned log_depth);
        longint t;
        longint t2;
        longint acc;
        longint s;
        t   = longint'(k) << (30 - log_depth);
        t2  = q30_mul(t, t);
        acc = K_C11;
        acc = K_C9 + q30_mul(acc, t2);
        acc = K_C7 + q30_mul(acc, t2);
        acc = K_C5 + q30_mul(acc, t2);
        acc = K_C3 + q30_mul(acc, t2);
        acc = K_C1 + q30_mul(acc, t2);
        s   = q30_mul(acc, t);
        if (s < 0)
            s = 0;
        s = (s + 64'sd32768) / 64'sd65536;
        if (s > 16384)
            s = 16384;
        return 15'(s);
    endfunction

    // A count of zero counts as one; counts above the limit are clamped.
    function automatic logic [8:0] clamp_count(input logic [8:0] c);
        if (c == 9'd0)
            return 9'd1;
        else if (int'(c) > MAX_STEPS)
            return 9'(MAX_STEPS);
        else
            return c;
    endfunction

endpackage

### sv/tvg_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module tvg_div #(
    parameter int NUM_W = 26
) (
    input  logic                     clk,
    input  logic [NUM_W-1:0]         n,
    input  logic [tvg_pkg::DIV_W-1:0] d,
    output logic [NUM_W-1:0]         q
);
    import tvg_pkg::*;

    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [NUM_W-1:0] quo_reg [NUM_W];
    logic [DIV_W-1:0] rem_reg [NUM_W];
    logic [DIV_W-1:0] den_reg [NUM_W];

    // Each stage shifts in one numerator bit and tries one subtraction.
    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [NUM_W-1:0] num_in;
        logic [NUM_W-1:0] quo_in;
        logic [DIV_W-1:0] rem_in;
        logic [DIV_W-1:0] den_in;
        logic [DIV_W:0]   trial;
        logic             fits;

        if (s == 0) begin : g_first
            assign num_in = n;
            assign quo_in = '0;
            assign rem_in = '0;
            assign den_in = d;
        end
        else begin : g_next
            assign num_in = num_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
        end

        assign trial = {rem_in, num_in[NUM_W-1]};
        assign fits  = (trial >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            num_reg[s] <= num_in << 1;
            quo_reg[s] <= {quo_in[NUM_W-2:0], fits};
            rem_reg[s] <= fits ? DIV_W'(trial - {1'b0, den_in}) : trial[DIV_W-1:0];
            den_reg[s] <= den_in;
        end
    end

    assign q = quo_reg[NUM_W-1];

endmodule

### sv/tvg_top_placeholder.sv
// Quarter-wave sine table of the torus vertex generator with a registered read.
module tvg_trig_rom #(
    parameter int TRIG_TABLE_DEPTH = 1024
) (
    input  logic                                 clk,
    input  logic [$clog2(TRIG_TABLE_DEPTH+1)-1:0] addr,
    output logic [14:0]                          data
);
    import tvg_pkg::*;

    localparam int LOG_D = $clog2(TRIG_TABLE_DEPTH);

    logic [14:0] entries [0:TRIG_TABLE_DEPTH];
    logic [14:0] data_reg;

    // Entries are fixed at elaboration from the Taylor polynomial.
    for (genvar g = 0; g <= TRIG_TABLE_DEPTH; g++) begin : g_entry
        localparam logic [14:0] ENTRY = quarter_entry(g, LOG_D);
        assign entries[g] = ENTRY;
    end

    // Registered read.
    always_ff @(posedge clk)
    begin
        data_reg <= entries[addr];
    end

    assign data = data_reg;

endmodule

### sv/torus_vertex_generator_core.sv
// Top level of the torus triangle-strip vertex generator.
//
// Usage: load the four registers through the cfg channel (cfg_valid with
// cfg_ready, which is always high) while the block is idle. An item is a
// ring index and a segment index, taken when start is high and busy low.
// Each item gives two vertices on consecutive cycles, the ring i vertex first
// (outer_ring and last_of_pair low) and the ring i+1 vertex second, each
// shown for one cycle while result_valid is high.
// After each accepted item, busy is high for a single cycle while the second
// vertex enters the pipeline, which then takes one vertex per cycle; a new item
// can be taken before the previous one has left the pipeline.
// On its way to the ports a vertex passes the NW bit stages of the angle
// dividers, where NW = 9 + max(log2(depth)+3, 17), and then the seven stages
// behind them: S0, S1, S2, M1, M2, M3 and the output stage. The second vertex
// of each pair follows in the next cycle.
// Reset clears all pipeline valid bits and loads the register defaults
// (30, 20, 256, 64). The receiver cannot stall; results are never held.
// The table depth is expected to be a power of two.
module torus_vertex_generator_core #(
    parameter int TRIG_TABLE_DEPTH = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [7:0]                ring_index,
    input  logic [8:0]                seg_index,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  tvg_pkg::cfg_idx_t         cfg_index,
    input  logic [15:0]               cfg_data,
    output logic                      result_valid,
    output logic signed [15:0]        normal_x,
    output logic signed [15:0]        normal_y,
    output logic signed [15:0]        normal_z,
    output logic [16:0]               tex_u,
    output logic [16:0]               tex_v,
    output logic signed [17:0]        pos_x,
    output logic signed [17:0]        pos_y,
    output logic signed [16:0]        pos_z,
    output logic                      outer_ring,
    output logic                      last_of_pair
);
    import tvg_pkg::*;

    `include "torus_vertex_generator_core_macros.svh"

    localparam int LOG_D  = $clog2(TRIG_TABLE_DEPTH);
    localparam int L4     = LOG_D + 2;
    localparam int LOG8   = LOG_D + 3;
    localparam int FRAC_SH = 17;
    localparam int NSH    = (LOG8 > FRAC_SH) ? LOG8 : FRAC_SH;
    localparam int NW     = 9 + NSH;
    localparam int KW     = LOG_D + 1;

    // Configuration registers.
    logic [8:0]  major_count_reg;
    logic [8:0]  minor_count_reg;
    logic [15:0] major_radius_reg;
    logic [15:0] minor_radius_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_count_reg  <= 9'd30;
            minor_count_reg  <= 9'd20;
            major_radius_reg <= 16'd256;
            minor_radius_reg <= 16'd64;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAJOR_COUNT:  major_count_reg  <= cfg_data[8:0];
                REG_MINOR_COUNT:  minor_count_reg  <= cfg_data[8:0];
                REG_MAJOR_RADIUS: major_radius_reg <= cfg_data;
                REG_MINOR_RADIUS: minor_radius_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Issue stage: each item becomes two vertex jobs on consecutive cycles.
    logic       pend_reg;
    logic       e_valid_reg;
    logic       e_which_reg;
    logic [8:0] e_ring_reg;
    logic [8:0] e_seg_reg;
    logic [7:0] hold_ring_reg;
    logic       accept;

    assign accept = start && !busy;
    assign busy   = pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg    <= accept;
            e_valid_reg <= accept || pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e_which_reg   <= 1'b0;
            e_ring_reg    <= {1'b0, ring_index};
            e_seg_reg     <= seg_index;
            hold_ring_reg <= ring_index;
        end
        else if (pend_reg)
        begin
            e_which_reg <= 1'b1;
            e_ring_reg  <= {1'b0, hold_ring_reg} + 9'd1;
        end
    end

    // Angle and texture dividers: round(idx * scale / count).
    logic [8:0]       mc;
    logic [8:0]       nc;
    logic [NW-1:0]    qa_ph;
    logic [NW-1:0]    qa_fr;
    logic [NW-1:0]    qb_ph;
    logic [NW-1:0]    qb_fr;

    assign mc = clamp_count(major_count_reg);
    assign nc = clamp_count(minor_count_reg);

    tvg_div #(.NUM_W(NW)) u_div_a_ph (
        .clk (clk),
        .n   ((NW'(e_ring_reg) << LOG8) | NW'(mc)),
        .d   ({mc, 1'b0}),
        .q   (qa_ph)
    );

    tvg_div #(.NUM_W(NW)) u_div_a_fr (
        .clk (clk),
        .n   ((NW'(e_ring_reg) << FRAC_SH) | NW'(mc)),
        .d   ({mc, 1'b0}),
        .q   (qa_fr)
    );

    tvg_div #(.NUM_W(NW)) u_div_b_ph (
        .clk (clk),
        .n   ((NW'(e_seg_reg) << LOG8) | NW'(nc)),
        .d   ({nc, 1'b0}),
        .q   (qb_ph)
    );

    tvg_div #(.NUM_W(NW)) u_div_b_fr (
        .clk (clk),
        .n   ((NW'(e_seg_reg) << FRAC_SH) | NW'(nc)),
        .d   ({nc, 1'b0}),
        .q   (qb_fr)
    );

    // Valid and vertex order travel beside the dividers.
    logic [NW-1:0] dv_valid_reg;
    logic [NW-1:0] dv_which_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg <= '0;
        else
            dv_valid_reg <= {dv_valid_reg[NW-2:0], e_valid_reg};
    end

    always_ff @(posedge clk)
    begin
        dv_which_reg <= {dv_which_reg[NW-2:0], e_which_reg};
    end

    // Fold a phase onto the quarter wave: table index; the sign is the phase's top bit.
    function automatic logic [KW-1:0] fold_idx(input logic [L4-1:0] p);
        logic [LOG_D-1:0] r;
        r = p[LOG_D-1:0];
        return p[LOG_D] ? (KW'(TRIG_TABLE_DEPTH) - {1'b0, r}) : {1'b0, r};
    endfunction

    function automatic logic [16:0] frac_sat(input logic [NW-1:0] q);
        return (q > NW'(65536)) ? 17'h10000 : q[16:0];
    endfunction

    logic [L4-1:0] pa;
    logic [L4-1:0] pb;
    logic [L4-1:0] pa_c;
    logic [L4-1:0] pb_c;

    assign pa   = qa_ph[L4-1:0];
    assign pb   = qb_ph[L4-1:0];
    assign pa_c = pa + L4'(TRIG_TABLE_DEPTH);
    assign pb_c = pb + L4'(TRIG_TABLE_DEPTH);

    // Stage S0: table addresses and signs.
    logic          s0_valid_reg;
    logic          s0_which_reg;
    logic [KW-1:0] s0_ksa_reg;
    logic [KW-1:0] s0_kca_reg;
    logic [KW-1:0] s0_ksb_reg;
    logic [KW-1:0] s0_kcb_reg;
    logic [3:0]    s0_neg_reg;
    logic [16:0]   s0_u_reg;
    logic [16:0]   s0_v_reg;

    always_ff @(posedge clk)
    begin
        s0_which_reg <= dv_which_reg[NW-1];
        s0_ksa_reg   <= fold_idx(pa);
        s0_kca_reg   <= fold_idx(pa_c);
        s0_ksb_reg   <= fold_idx(pb);
        s0_kcb_reg   <= fold_idx(pb_c);
        s0_neg_reg   <= {pb_c[L4-1], pb[L4-1], pa_c[L4-1], pa[L4-1]};
        s0_u_reg     <= frac_sat(qa_fr);
        s0_v_reg     <= frac_sat(qb_fr);
    end

    // Stage S1: the four table reads.
    logic [14:0] s1_msa;
    logic [14:0] s1_mca;
    logic [14:0] s1_msb;
    logic [14:0] s1_mcb;

    tvg_trig_rom #(.TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)) u_rom_sa (
        .clk (clk), .addr (s0_ksa_reg), .data (s1_msa)
    );
    tvg_trig_rom #(.TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)) u_rom_ca (
        .clk (clk), .addr (s0_kca_reg), .data (s1_mca)
    );
    tvg_trig_rom #(.TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)) u_rom_sb (
        .clk (clk), .addr (s0_ksb_reg), .data (s1_msb)
    );
    tvg_trig_rom #(.TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)) u_rom_cb (
        .clk (clk), .addr (s0_kcb_reg), .data (s1_mcb)
    );

    logic        s1_valid_reg;
    logic        s1_which_reg;
    logic [3:0]  s1_neg_reg;
    logic [16:0] s1_u_reg;
    logic [16:0] s1_v_reg;

    always_ff @(posedge clk)
    begin
        s1_which_reg <= s0_which_reg;
        s1_neg_reg   <= s0_neg_reg;
        s1_u_reg     <= s0_u_reg;
        s1_v_reg     <= s0_v_reg;
    end

    // Stage S2: apply the quadrant signs.
    function automatic logic signed [15:0] apply_sign(input logic [14:0] m, input logic neg);
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    logic               s2_valid_reg;
    logic               s2_which_reg;
    logic signed [15:0] s2_sa_reg;
    logic signed [15:0] s2_ca_reg;
    logic signed [15:0] s2_sb_reg;
    logic signed [15:0] s2_cb_reg;
    logic [16:0]        s2_u_reg;
    logic [16:0]        s2_v_reg;

    always_ff @(posedge clk)
    begin
        s2_which_reg <= s1_which_reg;
        s2_sa_reg    <= apply_sign(s1_msa, s1_neg_reg[0]);
        s2_ca_reg    <= apply_sign(s1_mca, s1_neg_reg[1]);
        s2_sb_reg    <= apply_sign(s1_msb, s1_neg_reg[2]);
        s2_cb_reg    <= apply_sign(s1_mcb, s1_neg_reg[3]);
        s2_u_reg     <= s1_u_reg;
        s2_v_reg     <= s1_v_reg;
    end

    // Stage M1: first products.
    logic               m1_valid_reg;
    logic               m1_which_reg;
    logic signed [31:0] m1_cacb_reg;
    logic signed [31:0] m1_sacb_reg;
    logic signed [32:0] m1_mrcb_reg;
    logic signed [32:0] m1_mrsb_reg;
    logic signed [15:0] m1_ca_reg;
    logic signed [15:0] m1_sa_reg;
    logic signed [15:0] m1_sb_reg;
    logic [16:0]        m1_u_reg;
    logic [16:0]        m1_v_reg;

    always_ff @(posedge clk)
    begin
        m1_which_reg <= s2_which_reg;
        m1_cacb_reg  <= s2_ca_reg * s2_cb_reg;
        m1_sacb_reg  <= s2_sa_reg * s2_cb_reg;
        m1_mrcb_reg  <= $signed({1'b0, minor_radius_reg}) * s2_cb_reg;
        m1_mrsb_reg  <= $signed({1'b0, minor_radius_reg}) * s2_sb_reg;
        m1_ca_reg    <= s2_ca_reg;
        m1_sa_reg    <= s2_sa_reg;
        m1_sb_reg    <= s2_sb_reg;
        m1_u_reg     <= s2_u_reg;
        m1_v_reg     <= s2_v_reg;
    end

    // Stage M2: tube radius sum, rounded normals and z position.
    logic signed [33:0] m2_r_next;
    logic signed [31:0] nx_full;
    logic signed [31:0] ny_full;
    logic signed [32:0] pz_full;
    logic signed [16:0] m2_pz_next;

    always_comb
    begin
        m2_r_next = 34'(m1_mrcb_reg) + $signed({4'b0000, major_radius_reg, 14'd0});
        nx_full   = (m1_cacb_reg + 32'sd8192) >>> 14;
        ny_full   = (m1_sacb_reg + 32'sd8192) >>> 14;
        pz_full   = (m1_mrsb_reg + 33'sd8192) >>> 14;
        if (pz_full > 33'sd65535)
            m2_pz_next = 17'sd65535;
        else if (pz_full < -33'sd65536)
            m2_pz_next = -17'sd65536;
        else
            m2_pz_next = pz_full[16:0];
    end

    logic               m2_valid_reg;
    logic               m2_which_reg;
    logic signed [33:0] m2_r_reg;
    logic signed [15:0] m2_ca_reg;
    logic signed [15:0] m2_sa_reg;
    logic signed [15:0] m2_nx_reg;
    logic signed [15:0] m2_ny_reg;
    logic signed [15:0] m2_nz_reg;
    logic signed [16:0] m2_pz_reg;
    logic [16:0]        m2_u_reg;
    logic [16:0]        m2_v_reg;

    always_ff @(posedge clk)
    begin
        m2_which_reg <= m1_which_reg;
        m2_r_reg     <= m2_r_next;
        m2_ca_reg    <= m1_ca_reg;
        m2_sa_reg    <= m1_sa_reg;
        m2_nx_reg    <= nx_full[15:0];
        m2_ny_reg    <= ny_full[15:0];
        m2_nz_reg    <= m1_sb_reg;
        m2_pz_reg    <= m2_pz_next;
        m2_u_reg     <= m1_u_reg;
        m2_v_reg     <= m1_v_reg;
    end

    // Stage M3: x and y position products.
    logic               m3_valid_reg;
    logic               m3_which_reg;
    logic signed [49:0] m3_px_reg;
    logic signed [49:0] m3_py_reg;
    logic signed [15:0] m3_nx_reg;
    logic signed [15:0] m3_ny_reg;
    logic signed [15:0] m3_nz_reg;
    logic signed [16:0] m3_pz_reg;
    logic [16:0]        m3_u_reg;
    logic [16:0]        m3_v_reg;

    always_ff @(posedge clk)
    begin
        m3_which_reg <= m2_which_reg;
        m3_px_reg    <= m2_ca_reg * m2_r_reg;
        m3_py_reg    <= m2_sa_reg * m2_r_reg;
        m3_nx_reg    <= m2_nx_reg;
        m3_ny_reg    <= m2_ny_reg;
        m3_nz_reg    <= m2_nz_reg;
        m3_pz_reg    <= m2_pz_reg;
        m3_u_reg     <= m2_u_reg;
        m3_v_reg     <= m2_v_reg;
    end

    // Output stage: round x and y to Q10.8 and saturate.
    function automatic logic signed [17:0] pos_round(input logic signed [49:0] v);
        logic signed [49:0] t;
        t = (v + 50'sd134217728) >>> 28;
        if (t > 50'sd131071)
            return 18'sd131071;
        else if (t < -50'sd131072)
            return -18'sd131072;
        else
            return t[17:0];
    endfunction

    logic               out_valid_reg;
    logic               out_which_reg;
    logic signed [15:0] out_nx_reg;
    logic signed [15:0] out_ny_reg;
    logic signed [15:0] out_nz_reg;
    logic [16:0]        out_u_reg;
    logic [16:0]        out_v_reg;
    logic signed [17:0] out_px_reg;
    logic signed [17:0] out_py_reg;
    logic signed [16:0] out_pz_reg;

    always_ff @(posedge clk)
    begin
        out_which_reg <= m3_which_reg;
        out_nx_reg    <= m3_nx_reg;
        out_ny_reg    <= m3_ny_reg;
        out_nz_reg    <= m3_nz_reg;
        out_u_reg     <= m3_u_reg;
        out_v_reg     <= m3_v_reg;
        out_px_reg    <= pos_round(m3_px_reg);
        out_py_reg    <= pos_round(m3_py_reg);
        out_pz_reg    <= m3_pz_reg;
    end

    // Valid bits of the post-divider stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            m3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg  <= dv_valid_reg[NW-1];
            s1_valid_reg  <= s0_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            m1_valid_reg  <= s2_valid_reg;
            m2_valid_reg  <= m1_valid_reg;
            m3_valid_reg  <= m2_valid_reg;
            out_valid_reg <= m3_valid_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign normal_x     = out_nx_reg;
    assign normal_y     = out_ny_reg;
    assign normal_z     = out_nz_reg;
    assign tex_u        = out_u_reg;
    assign tex_v        = out_v_reg;
    assign pos_x        = out_px_reg;
    assign pos_y        = out_py_reg;
    assign pos_z        = out_pz_reg;
    assign outer_ring   = out_which_reg;
    assign last_of_pair = out_which_reg;

    // Checks on issue and pairing.
    `TVG_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `TVG_ASSERT_NEXT(a_busy_one_cycle, clk, rst_n, busy, !busy)
    `TVG_ASSERT_NEXT(a_pair_adjacent, clk, rst_n, result_valid && !last_of_pair,
        result_valid && last_of_pair)
    `TVG_ASSERT_SAME(a_ring_matches, clk, rst_n, result_valid, outer_ring == last_of_pair)

endmodule
